// File: sv/wuf_pkg.sv
// Shared widths, request codes, result beat type and saturating add for the union-find engine.
package wuf_pkg;

   localparam int NODE_W = 10;
   localparam int SUM_W  = 11;

   localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

   typedef logic [1:0] req_code_type;

   localparam req_code_type REQ_JOIN = 2'd1;
   localparam req_code_type REQ_INIT = 2'd2;

   typedef struct packed {
      logic [NODE_W-1:0] root_node;
      logic              merged;
      logic [SUM_W-1:0]  set_size;
      logic [SUM_W-1:0]  set_weight;
   } result_type;

   function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] lhs,
                                                input logic [SUM_W-1:0] rhs);
      logic [SUM_W:0] total;
      total = {1'b0, lhs} + {1'b0, rhs};
      return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
   endfunction

endpackage

// File: sv/wuf_node_mem.sv
// Node table memory: one write port, one registered read port.
module wuf_node_mem #(
   parameter int NODE_COUNT = 1024,
   parameter int WORD_W     = 33
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(NODE_COUNT)-1:0] wr_addr,
   input  logic [WORD_W-1:0]             wr_data,
   input  logic [$clog2(NODE_COUNT)-1:0] rd_addr,
   output logic [WORD_W-1:0]             rd_data
);

   logic [WORD_W-1:0] ram_ff [NODE_COUNT];
   logic [WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= ram_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/wuf_index_reduce.sv
// Two-stage reduction of a request node index modulo the table depth.
module wuf_index_reduce #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                          clock,
   input  logic                          load,
   input  logic [wuf_pkg::NODE_W-1:0]    node_in,
   output logic [$clog2(NODE_COUNT)-1:0] index_out
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int NW = wuf_pkg::NODE_W;
   localparam int SH = NW + IW;
   localparam longint unsigned RECIP =
      ((64'd1 << SH) + 64'(NODE_COUNT) - 64'd1) / 64'(NODE_COUNT);
   localparam logic [SH:0] RECIP_V = RECIP[SH:0];
   localparam logic [IW:0] NLIM    = (IW+1)'(NODE_COUNT);

   logic [SH+NW:0]    prod;
   logic [NW-1:0]     quot_ff;
   logic [NW-1:0]     value_ff;
   logic [NW+IW:0]    prod_n;
   logic [NW+IW:0]    diff;
   logic [NW+IW:0]    fixed;
   logic [IW-1:0]     index_ff;

   assign prod = {{(SH+1){1'b0}}, node_in} * {{NW{1'b0}}, RECIP_V};

   always_ff @(posedge clock) begin
      if (load) begin
         quot_ff  <= prod[SH+NW-1:SH];
         value_ff <= node_in;
      end
   end

   assign prod_n = {{(IW+1){1'b0}}, quot_ff} * {{NW{1'b0}}, NLIM};
   assign diff   = {{(IW+1){1'b0}}, value_ff} - prod_n;
   assign fixed  = (diff >= {{NW{1'b0}}, NLIM}) ? diff - {{NW{1'b0}}, NLIM} : diff;

   always_ff @(posedge clock) begin
      index_ff <= fixed[IW-1:0];
   end

   assign index_out = index_ff;

endmodule

// File: sv/wuf_ctrl.sv
// Sequencer for clear, find walk, path compression, join and init over the node memory.
module wuf_ctrl #(
   parameter int NODE_COUNT = 1024
) (
   input  logic                                              clock,
   input  logic                                              reset,
   input  logic                                              req_valid,
   input  wuf_pkg::req_code_type                             req_type,
   input  logic                                              req_weight_in,
   output logic                                              req_stall,
   input  logic [$clog2(NODE_COUNT)-1:0]                     idx_a,
   input  logic [$clog2(NODE_COUNT)-1:0]                     idx_b,
   output logic                                              wr_en,
   output logic [$clog2(NODE_COUNT)-1:0]                     wr_addr,
   output logic [$clog2(NODE_COUNT)+2*wuf_pkg::SUM_W:0]      wr_data,
   output logic [$clog2(NODE_COUNT)-1:0]                     rd_addr,
   input  logic [$clog2(NODE_COUNT)+2*wuf_pkg::SUM_W:0]      rd_data,
   input  logic                                              out_free,
   output logic                                              res_load,
   output wuf_pkg::result_type                               res
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int SW = wuf_pkg::SUM_W;
   localparam int NW = wuf_pkg::NODE_W;
   localparam int WW = IW + 2*SW + 1;
   localparam logic [IW:0]   NODE_LIMIT = (IW+1)'(NODE_COUNT);
   localparam logic [IW-1:0] LAST_NODE  = IW'(NODE_COUNT - 1);
   localparam logic [SW-1:0] SIZE_ONE   = SW'(1);
   localparam logic [SW-1:0] SUM_ZERO   = SW'(0);

   typedef enum logic [8:0] {
      ST_CLEAR    = 9'b000000001,
      ST_IDLE     = 9'b000000010,
      ST_REDUCE   = 9'b000000100,
      ST_DISPATCH = 9'b000001000,
      ST_WALK     = 9'b000010000,
      ST_COMPRESS = 9'b000100000,
      ST_MERGE_LO = 9'b001000000,
      ST_MERGE_HI = 9'b010000000,
      ST_REPORT   = 9'b100000000
   } state_type;

   state_type             state_ff, state_in;
   logic [IW-1:0]         clr_ff, clr_in;
   wuf_pkg::req_code_type type_ff, type_in;
   logic                  wgt_ff, wgt_in;
   logic                  phase_ff, phase_in;
   logic [IW-1:0]         cur_ff, cur_in;
   logic [IW-1:0]         start_ff, start_in;
   logic [IW-1:0]         root_ff, root_in;
   logic [SW-1:0]         rsize_ff, rsize_in;
   logic [SW-1:0]         rweight_ff, rweight_in;
   logic [IW-1:0]         x_ff, x_in;
   logic [SW-1:0]         xs_ff, xs_in;
   logic [SW-1:0]         xw_ff, xw_in;
   logic [IW-1:0]         major_ff, major_in;
   logic [SW-1:0]         sum_s_ff, sum_s_in;
   logic [SW-1:0]         sum_w_ff, sum_w_in;
   logic [IW:0]           step_ff, step_in;
   logic [IW-1:0]         res_root_ff, res_root_in;
   logic                  res_merged_ff, res_merged_in;
   logic [SW-1:0]         res_size_ff, res_size_in;
   logic [SW-1:0]         res_weight_ff, res_weight_in;

   logic                  rd_flag;
   logic [IW-1:0]         rd_parent;
   logic [SW-1:0]         rd_size;
   logic [SW-1:0]         rd_weight;
   logic                  walk_go;
   logic                  comp_go;
   logic                  swap;
   logic [IW-1:0]         major_node;
   logic [IW-1:0]         minor_node;
   logic [SW-1:0]         minor_size;
   logic [SW-1:0]         minor_weight;
   logic [SW-1:0]         wgt_wide;
   logic [IW+NW-1:0]      res_root_wide;

   assign rd_flag   = rd_data[WW-1];
   assign rd_parent = rd_data[WW-2 -: IW];
   assign rd_size   = rd_data[2*SW-1 -: SW];
   assign rd_weight = rd_data[SW-1:0];

   assign walk_go = !rd_flag && (step_ff < NODE_LIMIT);
   assign comp_go = (cur_ff != root_ff) && !rd_flag && (step_ff < NODE_LIMIT);

   assign swap         = xs_ff < rsize_ff;
   assign major_node   = swap ? root_ff : x_ff;
   assign minor_node   = swap ? x_ff : root_ff;
   assign minor_size   = swap ? xs_ff : rsize_ff;
   assign minor_weight = swap ? xw_ff : rweight_ff;
   assign wgt_wide     = {{(SW-1){1'b0}}, wgt_ff};

   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      type_in       = type_ff;
      wgt_in        = wgt_ff;
      phase_in      = phase_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      root_in       = root_ff;
      rsize_in      = rsize_ff;
      rweight_in    = rweight_ff;
      x_in          = x_ff;
      xs_in         = xs_ff;
      xw_in         = xw_ff;
      major_in      = major_ff;
      sum_s_in      = sum_s_ff;
      sum_w_in      = sum_w_ff;
      step_in       = step_ff;
      res_root_in   = res_root_ff;
      res_merged_in = res_merged_ff;
      res_size_in   = res_size_ff;
      res_weight_in = res_weight_ff;
      wr_en         = 1'b0;
      wr_addr       = cur_ff;
      wr_data       = '0;
      rd_addr       = cur_ff;
      res_load      = 1'b0;
      req_stall     = 1'b1;
      case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            wr_data = {1'b1, clr_ff, SIZE_ONE, SUM_ZERO};
            clr_in  = clr_ff + 1'b1;
            if (clr_ff == LAST_NODE) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               type_in  = req_type;
               wgt_in   = req_weight_in;
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (type_ff == wuf_pkg::REQ_INIT) begin
               wr_en         = 1'b1;
               wr_addr       = idx_a;
               wr_data       = {1'b1, idx_a, SIZE_ONE, wgt_wide};
               res_root_in   = idx_a;
               res_merged_in = 1'b0;
               res_size_in   = SIZE_ONE;
               res_weight_in = wgt_wide;
               state_in      = ST_REPORT;
            end else begin
               cur_in   = idx_a;
               start_in = idx_a;
               rd_addr  = idx_a;
               step_in  = '0;
               phase_in = 1'b0;
               state_in = ST_WALK;
            end
         end
         ST_WALK: begin
            if (walk_go) begin
               cur_in  = rd_parent;
               rd_addr = rd_parent;
               step_in = step_ff + 1'b1;
            end else begin
               root_in    = cur_ff;
               rsize_in   = rd_size;
               rweight_in = rd_weight;
               cur_in     = start_ff;
               rd_addr    = start_ff;
               step_in    = '0;
               state_in   = ST_COMPRESS;
            end
         end
         ST_COMPRESS: begin
            if (comp_go) begin
               wr_en   = 1'b1;
               wr_addr = cur_ff;
               wr_data = {1'b0, root_ff, rd_size, rd_weight};
               cur_in  = rd_parent;
               rd_addr = rd_parent;
               step_in = step_ff + 1'b1;
            end else if (type_ff == wuf_pkg::REQ_JOIN && !phase_ff) begin
               x_in     = root_ff;
               xs_in    = rsize_ff;
               xw_in    = rweight_ff;
               phase_in = 1'b1;
               cur_in   = idx_b;
               start_in = idx_b;
               rd_addr  = idx_b;
               step_in  = '0;
               state_in = ST_WALK;
            end else if (type_ff == wuf_pkg::REQ_JOIN) begin
               state_in = ST_MERGE_LO;
            end else begin
               res_root_in   = root_ff;
               res_merged_in = 1'b0;
               res_size_in   = rsize_ff;
               res_weight_in = rweight_ff;
               state_in      = ST_REPORT;
            end
         end
         ST_MERGE_LO: begin
            if (x_ff == root_ff) begin
               res_root_in   = x_ff;
               res_merged_in = 1'b0;
               res_size_in   = xs_ff;
               res_weight_in = xw_ff;
               state_in      = ST_REPORT;
            end else begin
               wr_en    = 1'b1;
               wr_addr  = minor_node;
               wr_data  = {1'b0, major_node, minor_size, minor_weight};
               major_in = major_node;
               sum_s_in = wuf_pkg::sat_add(xs_ff, rsize_ff);
               sum_w_in = wuf_pkg::sat_add(xw_ff, rweight_ff);
               state_in = ST_MERGE_HI;
            end
         end
         ST_MERGE_HI: begin
            wr_en         = 1'b1;
            wr_addr       = major_ff;
            wr_data       = {1'b1, major_ff, sum_s_ff, sum_w_ff};
            res_root_in   = major_ff;
            res_merged_in = 1'b1;
            res_size_in   = sum_s_ff;
            res_weight_in = sum_w_ff;
            state_in      = ST_REPORT;
         end
         ST_REPORT: begin
            if (out_free) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff       <= type_in;
      wgt_ff        <= wgt_in;
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      root_ff       <= root_in;
      rsize_ff      <= rsize_in;
      rweight_ff    <= rweight_in;
      x_ff          <= x_in;
      xs_ff         <= xs_in;
      xw_ff         <= xw_in;
      major_ff      <= major_in;
      sum_s_ff      <= sum_s_in;
      sum_w_ff      <= sum_w_in;
      step_ff       <= step_in;
      res_root_ff   <= res_root_in;
      res_merged_ff <= res_merged_in;
      res_size_ff   <= res_size_in;
      res_weight_ff <= res_weight_in;
   end

   assign res_root_wide  = {{NW{1'b0}}, res_root_ff};
   assign res.root_node  = res_root_wide[NW-1:0];
   assign res.merged     = res_merged_ff;
   assign res.set_size   = res_size_ff;
   assign res.set_weight = res_weight_ff;

endmodule

// File: sv/weighted_union_find.sv
// Top level of the disjoint-set engine: index reduction, node memory, sequencer, result register.
//
// Disjoint-set engine with union by size and path compression over NODE_COUNT nodes held
// in one single-port-read node memory. Every request beat gives exactly one response beat.
// After reset the engine clears the node memory with req_stall high. Each parent link
// costs one memory read, and the memory returns one entry per cycle: a find whose node
// sits d links below its root walks them to the root and again to compress them, a join
// does so for both nodes before the merge, and an init writes its node directly.
// Compression keeps d small, near log2 of the set size in the worst case. The response
// register lets a new request be taken while the previous response waits on rsp_stall.
module weighted_union_find #(
   parameter int NODE_COUNT = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_type,
   input  logic [9:0]  req_node_a,
   input  logic [9:0]  req_node_b,
   input  logic        req_weight_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [9:0]  rsp_root_node,
   output logic        rsp_merged,
   output logic [10:0] rsp_set_size,
   output logic [10:0] rsp_set_weight
);

   localparam int IW = $clog2(NODE_COUNT);
   localparam int WW = IW + 2*wuf_pkg::SUM_W + 1;

   logic                accept;
   logic [IW-1:0]       idx_a;
   logic [IW-1:0]       idx_b;
   logic                wr_en;
   logic [IW-1:0]       wr_addr;
   logic [WW-1:0]       wr_data;
   logic [IW-1:0]       rd_addr;
   logic [WW-1:0]       rd_data;
   logic                out_free;
   logic                res_load;
   wuf_pkg::result_type res;
   wuf_pkg::result_type rsp_ff;
   logic                rsp_valid_ff, rsp_valid_in;

   assign accept = req_valid && !req_stall;

   wuf_index_reduce #(.NODE_COUNT(NODE_COUNT)) u_reduce_a (
      .clock     (clock),
      .load      (accept),
      .node_in   (req_node_a),
      .index_out (idx_a)
   );

   wuf_index_reduce #(.NODE_COUNT(NODE_COUNT)) u_reduce_b (
      .clock     (clock),
      .load      (accept),
      .node_in   (req_node_b),
      .index_out (idx_b)
   );

   wuf_node_mem #(.NODE_COUNT(NODE_COUNT), .WORD_W(WW)) u_node_mem (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   wuf_ctrl #(.NODE_COUNT(NODE_COUNT)) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_type      (req_type),
      .req_weight_in (req_weight_in),
      .req_stall     (req_stall),
      .idx_a         (idx_a),
      .idx_b         (idx_b),
      .wr_en         (wr_en),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .out_free      (out_free),
      .res_load      (res_load),
      .res           (res)
   );

   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = res_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_ff <= res;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_root_node  = rsp_ff.root_node;
   assign rsp_merged     = rsp_ff.merged;
   assign rsp_set_size   = rsp_ff.set_size;
   assign rsp_set_weight = rsp_ff.set_weight;

endmodule

// File: sv/wuf_checker.sv
// Port-level assertions for the union-find engine and the bind that attaches them.
module wuf_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [9:0]  rsp_root_node,
   input logic        rsp_merged,
   input logic [10:0] rsp_set_size,
   input logic [10:0] rsp_set_weight
);

   logic [1:0] pend_ff, pend_in;
   logic       req_beat;
   logic       rsp_beat;

   assign req_beat = req_valid && !req_stall;
   assign rsp_beat = rsp_valid && !rsp_stall;
   assign pend_in  = pend_ff + {1'b0, req_beat} - {1'b0, rsp_beat};

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_in;
      end
   end

   a_no_orphan_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pend_ff != 2'd0)
      else $error("response beat without a pending request");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_beat |-> pend_ff <= 2'd1)
      else $error("request beat taken while engine busy");

   a_merge_size: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_merged) |-> rsp_set_size >= 11'd2)
      else $error("merged set smaller than two nodes");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid && $stable(rsp_root_node)
         && $stable(rsp_merged) && $stable(rsp_set_size) && $stable(rsp_set_weight))
      else $error("stalled response beat changed");

endmodule

bind weighted_union_find wuf_checker u_wuf_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_stall      (req_stall),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_root_node  (rsp_root_node),
   .rsp_merged     (rsp_merged),
   .rsp_set_size   (rsp_set_size),
   .rsp_set_weight (rsp_set_weight)
);

// File: verif/tb_weighted_union_find.sv
`timescale 1ns / 100ps
// Self-checking testbench for the union-find engine: queued driver, monitor and predictor.
module tb_weighted_union_find;

   localparam int NODE_COUNT      = 1024;
   localparam int NODE_W          = wuf_pkg::NODE_W;
   localparam int SUM_W           = wuf_pkg::SUM_W;
   localparam int STUCK_LIMIT     = 20000;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int SAT_BASE        = 512;
   localparam int SAT_POOL        = 64;
   localparam int SAT_PAIRS       = 150;
   localparam int CHUNK_ITEMS     = 250;

   localparam wuf_pkg::req_code_type REQ_FIND  = 2'd0;
   localparam wuf_pkg::req_code_type REQ_SPARE = 2'd3;

   typedef struct packed {
      wuf_pkg::req_code_type code;
      logic [NODE_W-1:0]     node_a;
      logic [NODE_W-1:0]     node_b;
      logic                  weight;
   } request_type;

   logic              clock         = 1'b0;
   logic              reset         = 1'b1;
   logic              req_valid     = 1'b0;
   logic              req_stall;
   logic [1:0]        req_type      = '0;
   logic [9:0]        req_node_a    = '0;
   logic [9:0]        req_node_b    = '0;
   logic              req_weight_in = 1'b0;
   logic              rsp_valid;
   logic              rsp_stall     = 1'b0;
   logic [9:0]        rsp_root_node;
   logic              rsp_merged;
   logic [10:0]       rsp_set_size;
   logic [10:0]       rsp_set_weight;

   request_type         pending_requests[$];
   wuf_pkg::result_type expected_results[$];

   logic [NODE_W-1:0] node_parent[NODE_COUNT];
   bit                node_is_root[NODE_COUNT];
   logic [SUM_W-1:0]  set_count[NODE_COUNT];
   logic [SUM_W-1:0]  set_mass[NODE_COUNT];

   logic              req_fire = 1'b0;
   logic              rsp_fire = 1'b0;
   int                req_gap_max = 11;
   int                rsp_wait_max = 11;
   int                req_gap_left = 0;
   int                rsp_wait_left = 0;
   int                hold_off_requests = 0;
   int                hold_off_served = 0;
   int                hold_off_left = 0;
   int                stuck_cycles = 0;
   int                error_count = 0;

   weighted_union_find #(
      .NODE_COUNT(NODE_COUNT)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_type(req_type),
      .req_node_a(req_node_a),
      .req_node_b(req_node_b),
      .req_weight_in(req_weight_in),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_root_node(rsp_root_node),
      .rsp_merged(rsp_merged),
      .rsp_set_size(rsp_set_size),
      .rsp_set_weight(rsp_set_weight)
   );

   always #10 clock = ~clock;

   function automatic logic [SUM_W-1:0] clip_sum(input logic [SUM_W-1:0] lhs,
                                                 input logic [SUM_W-1:0] rhs);
      int total;
      total = int'(lhs) + int'(rhs);
      if (total > (1 << SUM_W) - 1) return {SUM_W{1'b1}};
      return SUM_W'(total);
   endfunction

   function automatic logic [NODE_W-1:0] locate_root(input logic [NODE_W-1:0] start);
      logic [NODE_W-1:0] top;
      logic [NODE_W-1:0] walk;
      logic [NODE_W-1:0] step_to;
      int                hops;
      top  = start;
      hops = 0;
      while (!node_is_root[top] && hops < NODE_COUNT) begin
         top = node_parent[top];
         hops++;
      end
      // point the walked path straight at the root
      walk = start;
      hops = 0;
      while (walk != top && !node_is_root[walk] && hops < NODE_COUNT) begin
         step_to           = node_parent[walk];
         node_parent[walk] = top;
         walk              = step_to;
         hops++;
      end
      return top;
   endfunction

   function automatic wuf_pkg::result_type apply_request(input request_type req);
      logic [NODE_W-1:0]   root_a;
      logic [NODE_W-1:0]   root_b;
      logic [NODE_W-1:0]   keep;
      logic [NODE_W-1:0]   lose;
      wuf_pkg::result_type res;
      res.merged = 1'b0;
      case (req.code)
         wuf_pkg::REQ_INIT: begin
            node_parent[req.node_a]  = req.node_a;
            node_is_root[req.node_a] = 1'b1;
            set_count[req.node_a]    = SUM_W'(1);
            set_mass[req.node_a]     = SUM_W'(req.weight);
            keep                     = req.node_a;
         end
         wuf_pkg::REQ_JOIN: begin
            root_a = locate_root(req.node_a);
            root_b = locate_root(req.node_b);
            keep   = root_a;
            if (root_a != root_b) begin
               // hang the smaller set under the larger, ties keep the first root
               if (set_count[root_a] < set_count[root_b]) begin
                  keep = root_b;
                  lose = root_a;
               end else begin
                  lose = root_b;
               end
               set_count[keep]    = clip_sum(set_count[keep], set_count[lose]);
               set_mass[keep]     = clip_sum(set_mass[keep], set_mass[lose]);
               node_parent[lose]  = keep;
               node_is_root[lose] = 1'b0;
               res.merged         = 1'b1;
            end
         end
         default: begin
            keep = locate_root(req.node_a);
         end
      endcase
      res.root_node  = keep;
      res.set_size   = set_count[keep];
      res.set_weight = set_mass[keep];
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [SUM_W-1:0] want,
                                input logic [SUM_W-1:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task automatic queue_request(input wuf_pkg::req_code_type code, input int node_a,
                                input int node_b, input int weight);
      request_type req;
      req.code   = code;
      req.node_a = NODE_W'(node_a);
      req.node_b = NODE_W'(node_b);
      req.weight = weight[0];
      pending_requests = {pending_requests, req};
   endtask

   task automatic drain_requests();
      while (pending_requests.size() != 0) @(posedge clock);
   endtask

   function automatic int random_node(input int base, input int span);
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, NODE_COUNT - 1);
      return base + $urandom_range(0, span);
   endfunction

   function automatic wuf_pkg::req_code_type random_code();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return wuf_pkg::REQ_JOIN;
      if (pick < 80) return REQ_FIND;
      if (pick < 93) return wuf_pkg::REQ_INIT;
      return REQ_SPARE;
   endfunction

   always @(posedge clock) begin : monitor
      wuf_pkg::result_type want;
      wuf_pkg::result_type predicted;
      request_type         taken;
      if (reset) begin
         req_fire     <= 1'b0;
         rsp_fire     <= 1'b0;
         stuck_cycles = 0;
      end else begin
         req_fire <= req_valid && !req_stall;
         rsp_fire <= rsp_valid && !rsp_stall;
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: unexpected beat, expected none, actual root %0d size %0d",
                        $time, rsp_root_node, rsp_set_size);
            end else begin
               want = expected_results.pop_front();
               compare_field("root_node", SUM_W'(want.root_node), SUM_W'(rsp_root_node));
               compare_field("merged", SUM_W'(want.merged), SUM_W'(rsp_merged));
               compare_field("set_size", want.set_size, rsp_set_size);
               compare_field("set_weight", want.set_weight, rsp_set_weight);
            end
         end
         if (req_valid && !req_stall) begin
            taken.code       = req_type;
            taken.node_a     = req_node_a;
            taken.node_b     = req_node_b;
            taken.weight     = req_weight_in;
            predicted        = apply_request(taken);
            expected_results = {expected_results, predicted};
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles = 0;
         else stuck_cycles++;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   always @(negedge clock) begin : driver
      request_type next_req;
      logic        next_valid;
      next_valid = 1'b0;
      if (!reset) begin
         if (req_valid && !req_fire) begin
            next_valid = 1'b1;
         end else begin
            if (req_valid) req_gap_left = $urandom_range(0, req_gap_max);
            if (req_gap_left > 0) begin
               req_gap_left--;
            end else if (pending_requests.size() != 0) begin
               next_req      = pending_requests.pop_front();
               req_type      <= next_req.code;
               req_node_a    <= next_req.node_a;
               req_node_b    <= next_req.node_b;
               req_weight_in <= next_req.weight;
               next_valid    = 1'b1;
            end
         end
      end
      req_valid <= next_valid;
   end

   always @(negedge clock) begin : receiver
      if (hold_off_requests != hold_off_served) begin
         hold_off_served = hold_off_requests;
         hold_off_left   = HOLD_OFF_CYCLES;
      end
      if (rsp_fire) rsp_wait_left = $urandom_range(0, rsp_wait_max);
      if (hold_off_left > 0) begin
         hold_off_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= (rsp_wait_left > 0);
         if (rsp_wait_left > 0 && rsp_valid === 1'b1) rsp_wait_left--;
      end
   end

   initial begin : stimulus
      int k;
      int chunk;
      int base;
      int span;
      int member;
      for (k = 0; k < NODE_COUNT; k++) begin
         node_parent[k]  = NODE_W'(k);
         node_is_root[k] = 1'b1;
         set_count[k]    = SUM_W'(1);
         set_mass[k]     = '0;
      end
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      queue_request(REQ_FIND, 0, 1023, 0);
      queue_request(REQ_FIND, 1023, 0, 1);
      queue_request(wuf_pkg::REQ_INIT, 1023, 0, 1);
      queue_request(wuf_pkg::REQ_INIT, 0, 1023, 1);
      queue_request(wuf_pkg::REQ_JOIN, 0, 1023, 0);
      queue_request(wuf_pkg::REQ_JOIN, 1023, 0, 1);
      queue_request(wuf_pkg::REQ_JOIN, 5, 5, 0);
      queue_request(REQ_SPARE, 1023, 682, 0);
      queue_request(wuf_pkg::REQ_JOIN, 2, 3, 0);
      queue_request(wuf_pkg::REQ_INIT, 4, 0, 1);
      queue_request(wuf_pkg::REQ_JOIN, 4, 5, 0);
      queue_request(wuf_pkg::REQ_JOIN, 2, 4, 1);
      queue_request(wuf_pkg::REQ_JOIN, 0, 2, 0);
      queue_request(REQ_FIND, 1023, 341, 0);
      queue_request(REQ_FIND, 5, 1023, 1);
      queue_request(wuf_pkg::REQ_INIT, 2, 0, 0);
      queue_request(REQ_FIND, 3, 682, 0);
      queue_request(wuf_pkg::REQ_INIT, 4, 0, 1);
      queue_request(REQ_FIND, 5, 341, 1);
      queue_request(wuf_pkg::REQ_JOIN, 4, 2, 1);
      queue_request(REQ_SPARE, 682, 1023, 1);
      queue_request(wuf_pkg::REQ_JOIN, 1022, 1021, 0);
      queue_request(REQ_FIND, 341, 682, 0);
      drain_requests();

      // build one set from a pool of nodes, then grow it by detaching a member and joining it back
      req_gap_max  = 0;
      rsp_wait_max = 0;
      for (k = 1; k < SAT_POOL; k++) begin
         queue_request(wuf_pkg::REQ_JOIN, SAT_BASE, SAT_BASE + k, 0);
      end
      hold_off_requests++;
      for (k = 0; k < SAT_PAIRS; k++) begin
         member = SAT_BASE + $urandom_range(1, SAT_POOL - 1);
         queue_request(wuf_pkg::REQ_INIT, member, $urandom_range(0, NODE_COUNT - 1), 1);
         if ($urandom_range(0, 1)) queue_request(wuf_pkg::REQ_JOIN, member, SAT_BASE, 1);
         else queue_request(wuf_pkg::REQ_JOIN, SAT_BASE, member, 0);
      end
      drain_requests();

      for (chunk = 0; chunk < 4; chunk++) begin
         req_gap_max  = (chunk % 2 == 0) ? 11 : 0;
         rsp_wait_max = (chunk < 2) ? 11 : 0;
         for (k = 0; k < CHUNK_ITEMS; k++) begin
            if (k % 40 == 0) begin
               span = $urandom_range(7, 95);
               base = $urandom_range(0, NODE_COUNT - 1 - span);
            end
            queue_request(random_code(), random_node(base, span), random_node(base, span),
                          $urandom_range(0, 1));
         end
         drain_requests();
      end

      while (pending_requests.size() != 0 || req_valid) @(posedge clock);
      while (expected_results.size() != 0) @(negedge clock);
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// File: sim.f
sv/wuf_pkg.sv
sv/wuf_node_mem.sv
sv/wuf_index_reduce.sv
sv/wuf_ctrl.sv
sv/weighted_union_find.sv
sv/wuf_checker.sv
verif/tb_weighted_union_find.sv
